@@ src/apid_pkg.sv @@
// Shared types, constants and register codes for the altitude PID thrust unit.
// Used by apid_mul, apid_div and the top level; depends on nothing else.
`default_nettype none

package apid_pkg;

    // Configuration port.
    localparam int GAIN_W     = 31;
    localparam int CFG_ADDR_W = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_KP_POSITION      = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KD_VELOCITY      = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KI_POSITION      = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ASCENT_RATE  = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_DESCENT_RATE = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_VEHICLE_MASS     = 4'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_MOTOR_FORCE  = 4'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_MOTOR_FORCE  = 4'd7;

    localparam logic [GAIN_W-1:0] RST_KP_POSITION      = 31'd0;
    localparam logic [GAIN_W-1:0] RST_KD_VELOCITY      = 31'd0;
    localparam logic [GAIN_W-1:0] RST_KI_POSITION      = 31'd0;
    localparam logic [GAIN_W-1:0] RST_MAX_ASCENT_RATE  = 31'd6553600;
    localparam logic [GAIN_W-1:0] RST_MAX_DESCENT_RATE = 31'd6553600;
    localparam logic [GAIN_W-1:0] RST_VEHICLE_MASS     = 31'd65536;
    localparam logic [GAIN_W-1:0] RST_MIN_MOTOR_FORCE  = 31'd0;
    localparam logic [GAIN_W-1:0] RST_MAX_MOTOR_FORCE  = 31'd6553600;

    // Shared multiplier: signed operand times unsigned gain, scaled by 2^-16.
    localparam int MUL_A_W     = 48;
    localparam int MUL_MAG_W   = 48;
    localparam int MUL_DIGIT_W = 16;
    localparam int MUL_DIGITS  = MUL_MAG_W / MUL_DIGIT_W;
    localparam int MUL_CNT_W   = 2;
    localparam int MUL_ACC_W   = MUL_MAG_W + GAIN_W;
    localparam int MUL_RES_W   = 62;

    // Serial divider for the tilt compensation.
    localparam int DIV_W      = 61;
    localparam int DIVISOR_W  = 15;
    localparam int DIV_CNT_W  = 6;
    localparam int TILT_SHIFT = 14;

    // Arithmetic constants.
    localparam logic signed [63:0] GRAVITY_Q16 = 64'sd642908;
    localparam logic [63:0]        SAT47       = 64'd140737488355327;
    localparam logic signed [63:0] FLOOR47     = -64'sd140737488355328;
    localparam logic [63:0]        SAT60       = 64'd1152921504606846976;

    // Division by ten as a multiplication by ceil(2^34 / 10).
    localparam logic [GAIN_W-1:0] RECIP10      = 31'h66666667;
    localparam int                MARGIN_LSB   = 18;
    localparam int                MARGIN_W     = 28;

    localparam logic signed [MUL_RES_W-1:0] OUT_MAX = 62'sd2147483647;
    localparam logic signed [MUL_RES_W-1:0] OUT_MIN = -62'sd2147483648;

    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_RUN,
        MUL_FIN
    } mul_state_t;

    typedef enum logic [0:0] {
        DIV_IDLE,
        DIV_RUN
    } div_state_t;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_PREP,
        SEQ_INT,
        SEQ_P,
        SEQ_D,
        SEQ_I,
        SEQ_MARG,
        SEQ_NUM,
        SEQ_DIV,
        SEQ_FORCE,
        SEQ_CLAMP,
        SEQ_OUT
    } seq_state_t;

endpackage

`default_nettype wire

@@ src/apid_mul.sv @@
// Shared multi-cycle multiplier: floor(a * g / 2^16), saturated to +-2^60.
// Depends on apid_pkg.
`default_nettype none

module apid_mul
    import apid_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic signed [MUL_A_W-1:0]   op_a,
    input  wire logic [GAIN_W-1:0]           op_g,
    output logic                             done,
    output logic signed [MUL_RES_W-1:0]      result
);

    mul_state_t                 state_reg, state_next;
    logic [MUL_CNT_W-1:0]       cnt_reg, cnt_next;
    logic [MUL_MAG_W-1:0]       mag_reg, mag_next;
    logic                       neg_reg, neg_next;
    logic [GAIN_W-1:0]          g_reg, g_next;
    logic [MUL_ACC_W-1:0]       acc_reg, acc_next;
    logic signed [MUL_RES_W-1:0] res_reg, res_next;
    logic                       done_reg, done_next;

    logic signed [MUL_A_W-1:0]  a_neg;
    logic [MUL_DIGIT_W+GAIN_W-1:0] partial;
    logic [MUL_ACC_W-1:0]       acc_sum;
    logic [63:0]                q;
    logic [63:0]                q_sat;
    logic signed [MUL_RES_W-1:0] q_pos;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MUL_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Operand and accumulator registers.
    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        g_reg   <= g_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    // One 16-bit digit of the magnitude per cycle, most significant first.
    always_comb begin
        a_neg   = -op_a;
        partial = mag_reg[MUL_MAG_W-1 -: MUL_DIGIT_W] * g_reg;
        acc_sum = {acc_reg[MUL_ACC_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}}
                  + MUL_ACC_W'(partial);
        // Floor for negative operands rounds the magnitude up.
        q       = 64'(acc_reg[MUL_ACC_W-1:MUL_DIGIT_W])
                  + 64'(neg_reg && (acc_reg[MUL_DIGIT_W-1:0] != '0));
        q_sat   = (q > SAT60) ? SAT60 : q;
        q_pos   = $signed({1'b0, q_sat[MUL_RES_W-2:0]});
    end

    // Sequencer of the multiplier.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        g_next     = g_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        case (state_reg)
            MUL_IDLE: begin
                if (start) begin
                    neg_next   = op_a[MUL_A_W-1];
                    mag_next   = op_a[MUL_A_W-1] ? a_neg : op_a;
                    g_next     = op_g;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = MUL_RUN;
                end
            end
            MUL_RUN: begin
                acc_next = acc_sum;
                mag_next = {mag_reg[MUL_MAG_W-MUL_DIGIT_W-1:0], {MUL_DIGIT_W{1'b0}}};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_DIGITS - 1)) begin
                    state_next = MUL_FIN;
                end
            end
            MUL_FIN: begin
                res_next   = neg_reg ? -q_pos : q_pos;
                done_next  = 1'b1;
                state_next = MUL_IDLE;
            end
            default: begin
                state_next = MUL_IDLE;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

@@ src/apid_div.sv @@
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on apid_pkg.
`default_nettype none

module apid_div
    import apid_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIV_W-1:0]      dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIV_W-1:0]           quotient
);

    div_state_t             state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_W-1:0]       quo_reg, quo_next;
    logic [DIVISOR_W-1:0]   rem_reg, rem_next;
    logic [DIVISOR_W-1:0]   dsr_reg, dsr_next;
    logic                   done_reg, done_next;

    logic [DIVISOR_W:0]     trial;
    logic [DIVISOR_W:0]     trial_diff;
    logic                   fits;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Shift register holds the remaining dividend bits and the quotient bits.
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    // One trial subtraction per cycle.
    always_comb begin
        trial      = {rem_reg, quo_reg[DIV_W-1]};
        trial_diff = trial - {1'b0, dsr_reg};
        fits       = (trial >= {1'b0, dsr_reg});
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        done_next  = 1'b0;
        case (state_reg)
            DIV_IDLE: begin
                if (start) begin
                    quo_next   = dividend;
                    rem_next   = '0;
                    dsr_next   = divisor;
                    cnt_next   = '0;
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN: begin
                quo_next = {quo_reg[DIV_W-2:0], fits};
                rem_next = fits ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    done_next  = 1'b1;
                    state_next = DIV_IDLE;
                end
            end
            default: begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ src/altitude_pid_thrust_unit.sv @@
// Altitude PID controller with feed-forward, producing a collective thrust command.
// Top level: sequencer and datapath; uses apid_pkg, apid_mul and apid_div.
//
// One beat in gives one beat out. An item is worked through in sequence on one
// shared multiplier (six products: integral increment, the P, D and I terms,
// the motor margin and the final mass scaling) and on a serial divider that
// produces one quotient bit per cycle for the tilt compensation. When the tilt
// cosine is zero or negative the divide and mass scaling are skipped. s_ready
// is low from acceptance until the result is in the output register. The
// output register lets the next beat be accepted while a result still waits.
// Configuration writes take effect at once and are meant for idle periods.
`default_nettype none

module altitude_pid_thrust_unit
    import apid_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    input  wire logic                    cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [GAIN_W-1:0]       cfg_wdata,

    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic signed [31:0]      s_target_altitude,
    input  wire logic signed [31:0]      s_target_climb,
    input  wire logic signed [31:0]      s_altitude_now,
    input  wire logic signed [31:0]      s_climb_now,
    input  wire logic signed [31:0]      s_accel_feedforward,
    input  wire logic signed [15:0]      s_tilt_cosine,
    input  wire logic [15:0]             s_time_step,

    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [31:0]           m_collective_thrust,
    output logic                         m_thrust_saturated
);

    // Configuration registers.
    logic [GAIN_W-1:0] kp_reg, kd_reg, ki_reg, asc_reg, desc_reg;
    logic [GAIN_W-1:0] mass_reg, fmin_reg, fmax_reg;

    // Sequencer and item registers.
    seq_state_t                  state_reg, state_next;
    logic                        issued_reg, issued_next;
    logic signed [31:0]          tgt_alt_reg, tgt_alt_next;
    logic signed [31:0]          tgt_climb_reg, tgt_climb_next;
    logic signed [31:0]          alt_reg, alt_next;
    logic signed [31:0]          climb_reg, climb_next;
    logic signed [31:0]          ff_reg, ff_next;
    logic signed [15:0]          tilt_reg, tilt_next;
    logic [15:0]                 dt_reg, dt_next;
    logic signed [32:0]          perr_reg, perr_next;
    logic signed [32:0]          verr_reg, verr_next;
    logic signed [31:0]          mdiff_reg, mdiff_next;
    logic                        tilt_bad_reg, tilt_bad_next;
    logic signed [47:0]          integ_reg, integ_next;
    logic signed [63:0]          sum_reg, sum_next;
    logic signed [34:0]          lo_reg, lo_next;
    logic signed [34:0]          hi_reg, hi_next;
    logic [46:0]                 num_mag_reg, num_mag_next;
    logic                        num_neg_reg, num_neg_next;
    logic signed [MUL_A_W-1:0]   u1_reg, u1_next;
    logic signed [MUL_RES_W-1:0] thrust_reg, thrust_next;
    logic signed [31:0]          fin_thrust_reg, fin_thrust_next;
    logic                        fin_sat_reg, fin_sat_next;
    logic signed [31:0]          m_thrust_reg, m_thrust_next;
    logic                        m_sat_reg, m_sat_next;
    logic                        m_valid_reg, m_valid_next;

    // Shared units.
    logic                        mul_start, mul_done;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic [GAIN_W-1:0]           mul_g;
    logic signed [MUL_RES_W-1:0] mul_res;
    logic                        div_start, div_done;
    logic [DIV_W-1:0]            div_quo;

    // Datapath helpers.
    logic signed [31:0]          climb_lo, climb_hi, climb_cmd;
    logic signed [31:0]          mdiff_neg;
    logic [30:0]                 mdiff_abs;
    logic signed [63:0]          res64;
    logic signed [63:0]          isum;
    logic signed [63:0]          nd;
    logic [63:0]                 nd_abs;
    logic signed [31:0]          marg_pos, marg;
    logic signed [32:0]          lo_sum, hi_sum;
    logic [46:0]                 q_mag;
    logic signed [MUL_A_W-1:0]   q_pos;
    logic signed [MUL_RES_W-1:0] lo_ext, hi_ext;
    logic signed [MUL_RES_W-1:0] t_bound;
    logic                        t_sat;
    logic signed [MUL_RES_W-1:0] t_out;
    logic                        t_out_sat;

    apid_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_g    (mul_g),
        .done    (mul_done),
        .result  (mul_res)
    );

    apid_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({num_mag_reg, {TILT_SHIFT{1'b0}}}),
        .divisor  (tilt_reg[DIVISOR_W-1:0]),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Configuration register file; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg   <= RST_KP_POSITION;
            kd_reg   <= RST_KD_VELOCITY;
            ki_reg   <= RST_KI_POSITION;
            asc_reg  <= RST_MAX_ASCENT_RATE;
            desc_reg <= RST_MAX_DESCENT_RATE;
            mass_reg <= RST_VEHICLE_MASS;
            fmin_reg <= RST_MIN_MOTOR_FORCE;
            fmax_reg <= RST_MAX_MOTOR_FORCE;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_KP_POSITION:      kp_reg   <= cfg_wdata;
                REG_KD_VELOCITY:      kd_reg   <= cfg_wdata;
                REG_KI_POSITION:      ki_reg   <= cfg_wdata;
                REG_MAX_ASCENT_RATE:  asc_reg  <= cfg_wdata;
                REG_MAX_DESCENT_RATE: desc_reg <= cfg_wdata;
                REG_VEHICLE_MASS:     mass_reg <= cfg_wdata;
                REG_MIN_MOTOR_FORCE:  fmin_reg <= cfg_wdata;
                REG_MAX_MOTOR_FORCE:  fmax_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Control state and the error integral.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SEQ_IDLE;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            integ_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            issued_reg  <= issued_next;
            m_valid_reg <= m_valid_next;
            integ_reg   <= integ_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        tgt_alt_reg    <= tgt_alt_next;
        tgt_climb_reg  <= tgt_climb_next;
        alt_reg        <= alt_next;
        climb_reg      <= climb_next;
        ff_reg         <= ff_next;
        tilt_reg       <= tilt_next;
        dt_reg         <= dt_next;
        perr_reg       <= perr_next;
        verr_reg       <= verr_next;
        mdiff_reg      <= mdiff_next;
        tilt_bad_reg   <= tilt_bad_next;
        sum_reg        <= sum_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        num_mag_reg    <= num_mag_next;
        num_neg_reg    <= num_neg_next;
        u1_reg         <= u1_next;
        thrust_reg     <= thrust_next;
        fin_thrust_reg <= fin_thrust_next;
        fin_sat_reg    <= fin_sat_next;
        m_thrust_reg   <= m_thrust_next;
        m_sat_reg      <= m_sat_next;
    end

    // Arithmetic around the shared units.
    always_comb begin
        // Commanded climb rate limited to the ascent and descent speeds.
        climb_lo  = -$signed({1'b0, asc_reg});
        climb_hi  = $signed({1'b0, desc_reg});
        if (tgt_climb_reg < climb_lo) begin
            climb_cmd = climb_lo;
        end else if (tgt_climb_reg > climb_hi) begin
            climb_cmd = climb_hi;
        end else begin
            climb_cmd = tgt_climb_reg;
        end

        mdiff_neg = -mdiff_reg;
        mdiff_abs = mdiff_reg[31] ? mdiff_neg[30:0] : mdiff_reg[30:0];

        res64 = $signed({{(64-MUL_RES_W){mul_res[MUL_RES_W-1]}}, mul_res});
        isum  = res64 + $signed({{16{integ_reg[47]}}, integ_reg});

        // Gravity minus the control sum, kept as sign and saturated magnitude.
        nd     = GRAVITY_Q16 - sum_reg;
        nd_abs = nd[63] ? 64'(-nd) : 64'(nd);

        // Motor margin of one tenth of the range, truncated toward zero.
        marg_pos = $signed({4'b0, mul_res[MARGIN_LSB +: MARGIN_W]});
        marg     = mdiff_reg[31] ? -marg_pos : marg_pos;
        lo_sum   = $signed({2'b0, fmin_reg}) + $signed({marg[31], marg});
        hi_sum   = $signed({2'b0, fmax_reg}) - $signed({marg[31], marg});

        // Tilt-compensated acceleration, saturated to 47 bits of magnitude.
        q_mag = ({3'b0, div_quo} > SAT47) ? SAT47[46:0] : div_quo[46:0];
        q_pos = $signed({1'b0, q_mag});

        // Bound the thrust, then saturate it to the output width.
        lo_ext = $signed({{(MUL_RES_W-35){lo_reg[34]}}, lo_reg});
        hi_ext = $signed({{(MUL_RES_W-35){hi_reg[34]}}, hi_reg});
        if (tilt_bad_reg) begin
            t_bound = hi_ext;
            t_sat   = 1'b1;
        end else if (thrust_reg < lo_ext) begin
            t_bound = lo_ext;
            t_sat   = 1'b1;
        end else if (thrust_reg > hi_ext) begin
            t_bound = hi_ext;
            t_sat   = 1'b1;
        end else begin
            t_bound = thrust_reg;
            t_sat   = 1'b0;
        end
        if (t_bound > OUT_MAX) begin
            t_out     = OUT_MAX;
            t_out_sat = 1'b1;
        end else if (t_bound < OUT_MIN) begin
            t_out     = OUT_MIN;
            t_out_sat = 1'b1;
        end else begin
            t_out     = t_bound;
            t_out_sat = t_sat;
        end
    end

    // Operands of the shared multiplier for each step.
    always_comb begin
        case (state_reg)
            SEQ_INT: begin
                mul_a = $signed({{(MUL_A_W-33){perr_reg[32]}}, perr_reg});
                mul_g = {(GAIN_W-16)'(0), dt_reg};
            end
            SEQ_P: begin
                mul_a = $signed({{(MUL_A_W-33){perr_reg[32]}}, perr_reg});
                mul_g = kp_reg;
            end
            SEQ_D: begin
                mul_a = $signed({{(MUL_A_W-33){verr_reg[32]}}, verr_reg});
                mul_g = kd_reg;
            end
            SEQ_I: begin
                mul_a = integ_reg;
                mul_g = ki_reg;
            end
            SEQ_MARG: begin
                mul_a = $signed({(MUL_A_W-31)'(0), mdiff_abs});
                mul_g = RECIP10;
            end
            SEQ_FORCE: begin
                mul_a = u1_reg;
                mul_g = mass_reg;
            end
            default: begin
                mul_a = '0;
                mul_g = '0;
            end
        endcase
    end

    // Sequencer: next state and register updates.
    always_comb begin
        state_next      = state_reg;
        issued_next     = issued_reg;
        tgt_alt_next    = tgt_alt_reg;
        tgt_climb_next  = tgt_climb_reg;
        alt_next        = alt_reg;
        climb_next      = climb_reg;
        ff_next         = ff_reg;
        tilt_next       = tilt_reg;
        dt_next         = dt_reg;
        perr_next       = perr_reg;
        verr_next       = verr_reg;
        mdiff_next      = mdiff_reg;
        tilt_bad_next   = tilt_bad_reg;
        integ_next      = integ_reg;
        sum_next        = sum_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        num_mag_next    = num_mag_reg;
        num_neg_next    = num_neg_reg;
        u1_next         = u1_reg;
        thrust_next     = thrust_reg;
        fin_thrust_next = fin_thrust_reg;
        fin_sat_next    = fin_sat_reg;
        m_thrust_next   = m_thrust_reg;
        m_sat_next      = m_sat_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        mul_start       = 1'b0;
        div_start       = 1'b0;
        s_ready         = 1'b0;

        case (state_reg)
            SEQ_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    tgt_alt_next   = s_target_altitude;
                    tgt_climb_next = s_target_climb;
                    alt_next       = s_altitude_now;
                    climb_next     = s_climb_now;
                    ff_next        = s_accel_feedforward;
                    tilt_next      = s_tilt_cosine;
                    dt_next        = s_time_step;
                    state_next     = SEQ_PREP;
                end
            end
            SEQ_PREP: begin
                perr_next = $signed({tgt_alt_reg[31], tgt_alt_reg})
                            - $signed({alt_reg[31], alt_reg});
                verr_next = $signed({climb_cmd[31], climb_cmd})
                            - $signed({climb_reg[31], climb_reg});
                mdiff_next    = $signed({1'b0, fmax_reg}) - $signed({1'b0, fmin_reg});
                tilt_bad_next = tilt_reg[15] || (tilt_reg == '0);
                issued_next   = 1'b0;
                state_next    = SEQ_INT;
            end
            SEQ_INT: begin
                mul_start   = !issued_reg;
                issued_next = 1'b1;
                if (mul_done) begin
                    // Saturating accumulator of the position error.
                    if (isum > $signed(SAT47)) begin
                        integ_next = SAT47[47:0];
                    end else if (isum < FLOOR47) begin
                        integ_next = FLOOR47[47:0];
                    end else begin
                        integ_next = isum[47:0];
                    end
                    issued_next = 1'b0;
                    state_next  = SEQ_P;
                end
            end
            SEQ_P: begin
                mul_start   = !issued_reg;
                issued_next = 1'b1;
                if (mul_done) begin
                    sum_next    = res64 + $signed({{32{ff_reg[31]}}, ff_reg});
                    issued_next = 1'b0;
                    state_next  = SEQ_D;
                end
            end
            SEQ_D: begin
                mul_start   = !issued_reg;
                issued_next = 1'b1;
                if (mul_done) begin
                    sum_next    = sum_reg + res64;
                    issued_next = 1'b0;
                    state_next  = SEQ_I;
                end
            end
            SEQ_I: begin
                mul_start   = !issued_reg;
                issued_next = 1'b1;
                if (mul_done) begin
                    sum_next    = sum_reg + res64;
                    issued_next = 1'b0;
                    state_next  = SEQ_MARG;
                end
            end
            SEQ_MARG: begin
                mul_start   = !issued_reg;
                issued_next = 1'b1;
                if (mul_done) begin
                    lo_next     = $signed({lo_sum, 2'b00});
                    hi_next     = $signed({hi_sum, 2'b00});
                    issued_next = 1'b0;
                    state_next  = SEQ_NUM;
                end
            end
            SEQ_NUM: begin
                num_neg_next = nd[63];
                num_mag_next = (nd_abs > SAT47) ? SAT47[46:0] : nd_abs[46:0];
                issued_next  = 1'b0;
                // Tilt not positive: thrust goes straight to the upper bound.
                state_next   = tilt_bad_reg ? SEQ_CLAMP : SEQ_DIV;
            end
            SEQ_DIV: begin
                div_start   = !issued_reg;
                issued_next = 1'b1;
                if (div_done) begin
                    u1_next     = num_neg_reg ? -q_pos : q_pos;
                    issued_next = 1'b0;
                    state_next  = SEQ_FORCE;
                end
            end
            SEQ_FORCE: begin
                mul_start   = !issued_reg;
                issued_next = 1'b1;
                if (mul_done) begin
                    thrust_next = mul_res;
                    issued_next = 1'b0;
                    state_next  = SEQ_CLAMP;
                end
            end
            SEQ_CLAMP: begin
                fin_thrust_next = t_out[31:0];
                fin_sat_next    = t_out_sat;
                state_next      = SEQ_OUT;
            end
            SEQ_OUT: begin
                // Load the output register once the previous beat has gone.
                if (!m_valid_reg || m_ready) begin
                    m_thrust_next = fin_thrust_reg;
                    m_sat_next    = fin_sat_reg;
                    m_valid_next  = 1'b1;
                    state_next    = SEQ_IDLE;
                end
            end
            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign m_valid             = m_valid_reg;
    assign m_collective_thrust = m_thrust_reg;
    assign m_thrust_saturated  = m_sat_reg;

endmodule

`default_nettype wire

@@ src/apid_checker.sv @@
// Port-level assertions for the altitude PID thrust unit, and the bind that
// attaches them to altitude_pid_thrust_unit. No package dependency.
`default_nettype none

module apid_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_collective_thrust,
    input wire logic        m_thrust_saturated
);

    // A result beat that is held back keeps its payload.
    property p_out_hold;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_collective_thrust)
                                && $stable(m_thrust_saturated);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result beat changed while stalled");

    // The block works on one item at a time, so it closes after an accept.
    property p_one_at_a_time;
        @(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready;
    endproperty
    a_one_at_a_time: assert property (p_one_at_a_time)
        else $error("input accepted while an item is in progress");

    // Both thrust bounds are non-negative, so the command never is negative.
    property p_thrust_sign;
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_collective_thrust[31];
    endproperty
    a_thrust_sign: assert property (p_thrust_sign)
        else $error("negative collective thrust");

    // Coming out of reset there is no result pending.
    property p_reset_empty;
        @(posedge aclk)
        $rose(aresetn) |-> !m_valid;
    endproperty
    a_reset_empty: assert property (p_reset_empty)
        else $error("result beat pending right after reset");

endmodule

bind altitude_pid_thrust_unit apid_checker u_apid_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_valid             (s_valid),
    .s_ready             (s_ready),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_collective_thrust (m_collective_thrust),
    .m_thrust_saturated  (m_thrust_saturated)
);

`default_nettype wire
